[sv/opsm_pkg.sv]
// ----------------------------------------------------------------------------
// opsm_pkg
// Shared constants and control structs for the ordered pattern sequence
// matcher: default sizes and the per-cell load and step controls.
// ----------------------------------------------------------------------------
package opsm_pkg;

    // Default sizes
    localparam int DEF_MAX_GROUPS      = 16;
    localparam int DEF_MAX_PATTERN_LEN = 16;
    localparam int DEF_DATA_WIDTH      = 32;

    // Fixed field widths
    localparam int GC_W    = 5;   // group_count register
    localparam int IDX_W   = 4;   // group_index / element_position
    localparam int VAL_W   = 32;  // element_value
    localparam int FOUND_W = 5;   // groups_found

    localparam logic [GC_W-1:0] GC_RESET = GC_W'(1);

    // Pattern load broadcast to every cell
    typedef struct packed {
        logic we;    // write this request's value / end mark
        logic last;  // request closes the pattern: rewrite end marks
    } ld_ctl_t;

    // Window and prefix-flag step broadcast to every cell
    typedef struct packed {
        logic shift; // advance window and prefix flags by one element
        logic clear; // drop all partial matches
    } step_ctl_t;

endpackage

[sv/opsm_cell.sv]
// ----------------------------------------------------------------------------
// opsm_cell
// One position of the matcher: holds one text window tap, the pattern
// element of this position for every group, the end-of-pattern mark for
// every group, and the prefix-match flag handed on to the next cell.
// ----------------------------------------------------------------------------
module opsm_cell
    import opsm_pkg::*;
#(
    parameter int MAX_GROUPS = DEF_MAX_GROUPS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int GAW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pattern load
    input  ld_ctl_t               ld,
    input  logic                  pos_sel,
    input  logic [GAW-1:0]        ld_grp,
    input  logic [DATA_WIDTH-1:0] ld_value,
    // group whose pattern is presented in the next cycle
    input  logic [GAW-1:0]        rd_addr,
    // window / flag step
    input  step_ctl_t             step,
    input  logic [DATA_WIDTH-1:0] feed,
    input  logic [DATA_WIDTH-1:0] win_in,
    output logic [DATA_WIDTH-1:0] win_out,
    input  logic                  flag_in,
    output logic                  flag_out,
    output logic                  hit
);

    logic [DATA_WIDTH-1:0] pat_mem_reg [MAX_GROUPS];
    logic [DATA_WIDTH-1:0] pat_rd_reg;
    logic [MAX_GROUPS-1:0] end_mark_reg;
    logic                  end_rd_reg;
    logic                  flag_reg;
    logic                  flag_next;
    logic [DATA_WIDTH-1:0] win_reg;

    // Pattern element store, registered read of the current group
    always_ff @(posedge clk)
    begin
        if (ld.we && pos_sel)
        begin
            pat_mem_reg[ld_grp] <= ld_value;
        end
        pat_rd_reg <= pat_mem_reg[rd_addr];
    end

    // End marks: set in the cell at the pattern's last position, cleared elsewhere
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_mark_reg <= '0;
            end_rd_reg   <= 1'b0;
        end
        else
        begin
            if (ld.we && ld.last)
            begin
                end_mark_reg[ld_grp] <= pos_sel;
            end
            end_rd_reg <= end_mark_reg[rd_addr];
        end
    end

    // Prefix through this position matches, ending at the fed element
    assign flag_next = flag_in && (feed == pat_rd_reg);
    assign hit       = flag_next && end_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (step.clear)
        begin
            flag_reg <= 1'b0;
        end
        else if (step.shift)
        begin
            flag_reg <= flag_next;
        end
    end

    // Window tap
    always_ff @(posedge clk)
    begin
        if (step.shift)
        begin
            win_reg <= win_in;
        end
    end

    assign flag_out = flag_reg;
    assign win_out  = win_reg;

endmodule

[sv/ordered_pattern_sequence_match.sv]
// ----------------------------------------------------------------------------
// ordered_pattern_sequence_match
// Finds a list of patterns in a text stream, in order and without overlap,
// with a row of cells that each track one pattern position.
// ----------------------------------------------------------------------------
// A request with func = 1 feeds one text element; the cells compare it
// against the current pattern at once and hand partial matches along the
// row. The request that ends the text (is_last) yields one result:
// all_found and groups_found. A request with func = 0 loads one pattern
// element, after which the block replays its window of MAX_PATTERN_LEN
// text elements through the cells against the new pattern, holding
// req_stall high for the whole replay. Besides the replay, a text-end request
// waits while an earlier result is still held by res_stall. The user must
// write group_count through cfg_we / cfg_wdata only while no request is in
// flight; the block itself does not enforce this.
module ordered_pattern_sequence_match
    import opsm_pkg::*;
#(
    parameter int MAX_GROUPS      = DEF_MAX_GROUPS,
    parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN,
    parameter int DATA_WIDTH      = DEF_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [GC_W-1:0]       cfg_wdata,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  func,
    input  logic [IDX_W-1:0]      group_index,
    input  logic [IDX_W-1:0]      element_position,
    input  logic signed [VAL_W-1:0] element_value,
    input  logic                  is_last,
    // result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic                  all_found,
    output logic [FOUND_W-1:0]    groups_found
);

    localparam int N   = MAX_PATTERN_LEN;
    localparam int GAW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW  = $clog2(MAX_GROUPS + 1);
    localparam int SW  = $clog2(N + 1);

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_REPLAY  = 1'b1;

    logic                  state_reg, state_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [CW-1:0]         cur_reg, cur_next, cur_after;
    logic [SW-1:0]         span_reg, span_next;
    logic [GC_W-1:0]       gc_reg;
    logic                  res_valid_reg;
    logic                  all_found_reg;
    logic [FOUND_W-1:0]    groups_found_reg;

    logic                  req_take;
    logic                  text_step;
    logic                  text_last;
    logic                  load_take;
    logic                  load_ok;
    logic                  replay_feed;
    logic                  chain_start;
    logic                  match_take;
    logic [31:0]           goal;
    logic [GAW-1:0]        rd_addr;
    logic [DATA_WIDTH-1:0] value_in;
    logic [DATA_WIDTH-1:0] feed;
    ld_ctl_t               ld;
    step_ctl_t             step;

    logic [DATA_WIDTH-1:0] win   [N];
    logic [N-1:0]          flag;
    logic [N-1:0]          hit;

    // Request acceptance
    assign req_stall = (state_reg == ST_REPLAY)
                     || (res_valid_reg && res_stall && func && is_last);
    assign req_take  = req_valid && !req_stall;
    assign text_step = req_take && func;
    assign text_last = text_step && is_last;
    assign load_ok   = ({28'd0, group_index} < 32'(MAX_GROUPS))
                     && ({28'd0, element_position} < 32'(N));
    assign load_take = req_take && !func && load_ok;

    // Effective group goal, capped at the number of groups held
    assign goal = ({27'd0, gc_reg} > 32'(MAX_GROUPS)) ? 32'(MAX_GROUPS)
                                                      : {27'd0, gc_reg};

    // Element fed to the cells: new text, or the oldest tap during a replay
    assign value_in    = DATA_WIDTH'($unsigned(element_value));
    assign replay_feed = (state_reg == ST_REPLAY) && (step_reg != '0);
    assign feed        = replay_feed ? win[N-1] : value_in;

    // During a replay only elements since the last match may open a prefix
    assign chain_start = text_step
                      || (replay_feed && ((32'(step_reg) + 32'(span_reg)) > 32'(N)));

    assign ld.we   = load_take;
    assign ld.last = is_last;

    assign match_take = text_step && (32'(cur_reg) < goal) && (|hit);

    assign step.shift = text_step || replay_feed;
    assign step.clear = ((state_reg == ST_REPLAY) && (step_reg == '0))
                     || (text_step && (match_take || is_last));

    // Row of cells
    for (genvar j = 0; j < N; j++)
    begin : g_cell
        logic win_src_flag;
        logic [DATA_WIDTH-1:0] win_src;

        if (j == 0)
        begin : g_head
            assign win_src      = feed;
            assign win_src_flag = chain_start;
        end
        else
        begin : g_body
            assign win_src      = win[j-1];
            assign win_src_flag = flag[j-1];
        end

        opsm_cell #(
            .MAX_GROUPS (MAX_GROUPS),
            .DATA_WIDTH (DATA_WIDTH),
            .GAW        (GAW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ld       (ld),
            .pos_sel  ({28'd0, element_position} == 32'(j)),
            .ld_grp   (GAW'(group_index)),
            .ld_value (value_in),
            .rd_addr  (rd_addr),
            .step     (step),
            .feed     (feed),
            .win_in   (win_src),
            .win_out  (win[j]),
            .flag_in  (win_src_flag),
            .flag_out (flag[j]),
            .hit      (hit[j])
        );
    end

    // Group and span bookkeeping
    assign cur_after = match_take ? (cur_reg + CW'(1)) : cur_reg;

    always_comb
    begin
        cur_next  = cur_reg;
        span_next = span_reg;
        if (text_step)
        begin
            if (is_last)
            begin
                cur_next  = '0;
                span_next = '0;
            end
            else if (match_take)
            begin
                cur_next  = cur_after;
                span_next = '0;
            end
            else if (32'(span_reg) < 32'(N))
            begin
                span_next = span_reg + SW'(1);
            end
        end
    end

    // Pattern read address follows the group of the next cycle
    assign rd_addr = (32'(cur_next) < 32'(MAX_GROUPS)) ? GAW'(cur_next) : '0;

    // Replay sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load_take)
                begin
                    state_next = ST_REPLAY;
                    step_next  = '0;
                end
            end
            ST_REPLAY:
            begin
                if (32'(step_reg) == 32'(N))
                begin
                    state_next = ST_IDLE;
                end
                step_next = step_reg + SW'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            cur_reg   <= '0;
            span_reg  <= '0;
            gc_reg    <= GC_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cur_reg   <= cur_next;
            span_reg  <= span_next;
            if (cfg_we)
            begin
                gc_reg <= cfg_wdata;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (text_last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_last)
        begin
            all_found_reg    <= (32'(cur_after) >= goal);
            groups_found_reg <= FOUND_W'(cur_after);
        end
    end

    assign res_valid    = res_valid_reg;
    assign all_found    = all_found_reg;
    assign groups_found = groups_found_reg;

`ifndef SYNTHESIS
    // A pattern load always starts a window replay
    a_load_replays: assert property (@(posedge clk) disable iff (!rst_n)
        load_take |=> (state_reg == ST_REPLAY) && (step_reg == '0))
        else $error("pattern load did not start a replay");

    // A new result appears only after the request that ends the text
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg && res_stall)) |-> $past(text_last))
        else $error("result without a text-end request");

    // Group counter never passes the number of groups held
    a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cur_reg) <= 32'(MAX_GROUPS))
        else $error("current group out of range");

    // A match always restarts the span count
    a_match_span: assert property (@(posedge clk) disable iff (!rst_n)
        match_take |=> (span_reg == '0))
        else $error("span not restarted after match");
`endif

endmodule
